// File: hdl/aip_pkg.sv
// ----------------------------------------------------------------------------
// aip_pkg
// shared types and constants of the ascii integer parser
// ----------------------------------------------------------------------------
package aip_pkg;

    localparam int unsigned CHAR_W    = 8;
    localparam int unsigned VALUE_W   = 64;
    localparam int unsigned COUNT_W   = 5;
    localparam int unsigned PADDR_W   = 4;
    localparam int unsigned PDATA_W   = 64;

    localparam logic [VALUE_W-1:0] DEC_QUOT_LIMIT = 64'hFFFF_FFFF_FFFF_FFFF / 64'd10;
    localparam logic [VALUE_W-1:0] LIMIT_RESET    = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [COUNT_W-1:0] HEX_MAX_DIGITS = 5'd16;

    localparam logic [CHAR_W-1:0] CHAR_NUL     = 8'h00;
    localparam logic [CHAR_W-1:0] CHAR_ZERO    = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 8'h61;
    localparam logic [CHAR_W-1:0] CASE_BIT     = 8'h20;
    localparam logic [CHAR_W-1:0] DEC_MAX      = 8'd9;
    localparam logic [CHAR_W-1:0] HEX_ALPHA_MAX = 8'd5;
    localparam logic [CHAR_W-1:0] HEX_TEN      = 8'h0A;
    localparam logic [CHAR_W-1:0] DEC_TOP_DIGIT = 8'd5;

    // register index, taken from paddr[3]
    localparam logic REG_RADIX_MODE  = 1'b0;
    localparam logic REG_VALUE_LIMIT = 1'b1;

    localparam logic RADIX_DEC = 1'b0;
    localparam logic RADIX_HEX = 1'b1;

    typedef struct packed {
        logic               radix_mode;
        logic [VALUE_W-1:0] value_limit;
    } t_cfg;

endpackage

// File: hdl/aip_cfg_regs.sv
// ----------------------------------------------------------------------------
// aip_cfg_regs
// apb register file: radix mode and value limit
// ----------------------------------------------------------------------------
module aip_cfg_regs (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [aip_pkg::PADDR_W-1:0]  paddr,
    input  logic [aip_pkg::PDATA_W-1:0]  pwdata,
    output logic [aip_pkg::PDATA_W-1:0]  prdata,
    output logic                         pready,
    output aip_pkg::t_cfg                o_cfg
);
    import aip_pkg::*;

    logic               r_radix_mode;
    logic [VALUE_W-1:0] r_value_limit;
    logic               w_write;
    logic               w_index;

    assign pready  = 1'b1;
    assign w_write = psel & penable & pwrite;
    assign w_index = paddr[PADDR_W-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radix_mode  <= RADIX_DEC;
            r_value_limit <= LIMIT_RESET;
        end else if (w_write) begin
            unique case (w_index)
                REG_RADIX_MODE:  r_radix_mode  <= pwdata[0];
                REG_VALUE_LIMIT: r_value_limit <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_index)
            REG_RADIX_MODE:  prdata = {{(PDATA_W-1){1'b0}}, r_radix_mode};
            REG_VALUE_LIMIT: prdata = r_value_limit;
            default:         prdata = '0;
        endcase
    end

    assign o_cfg.radix_mode  = r_radix_mode;
    assign o_cfg.value_limit = r_value_limit;

endmodule

// File: hdl/aip_accum.sv
// ----------------------------------------------------------------------------
// aip_accum
// digit decode, accumulator update and result register
// ----------------------------------------------------------------------------
module aip_accum (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_fire,
    input  logic [aip_pkg::CHAR_W-1:0]   i_char,
    input  aip_pkg::t_cfg                i_cfg,
    input  logic                         i_out_stall,
    output logic                         o_out_valid,
    output logic [aip_pkg::VALUE_W-1:0]  o_parsed_value,
    output logic                         o_fail_flag
);
    import aip_pkg::*;

    logic [VALUE_W-1:0] r_acc,   n_acc;
    logic [COUNT_W-1:0] r_count, n_count;
    logic               r_seen,  n_seen;
    logic               r_err,   n_err;
    logic               r_out_valid;
    logic [VALUE_W-1:0] r_value;
    logic               r_fail;

    logic [CHAR_W-1:0]  w_dnum;
    logic [CHAR_W-1:0]  w_dalpha;
    logic [CHAR_W-1:0]  w_hex_d;
    logic               w_hex_bad;
    logic               w_dec_bad;
    logic               w_dec_ovf;
    logic               w_hex_ovf;
    logic [VALUE_W-1:0] w_dec_acc;
    logic [VALUE_W-1:0] w_hex_acc;
    logic               w_is_nul;
    logic               w_ok;

    assign w_is_nul  = (i_char == CHAR_NUL);
    assign w_dnum    = i_char - CHAR_ZERO;
    assign w_dalpha  = (i_char | CASE_BIT) - CHAR_LOWER_A;
    assign w_dec_bad = (w_dnum > DEC_MAX);
    assign w_hex_bad = w_dec_bad & (w_dalpha > HEX_ALPHA_MAX);
    assign w_hex_d   = w_dec_bad ? (w_dalpha + HEX_TEN) : w_dnum;
    assign w_dec_ovf = (r_acc > DEC_QUOT_LIMIT)
                     | ((r_acc == DEC_QUOT_LIMIT) & (w_dnum > DEC_TOP_DIGIT));
    assign w_hex_ovf = (r_count >= HEX_MAX_DIGITS);
    // times ten as shift-add
    assign w_dec_acc = {r_acc[VALUE_W-4:0], 3'b000} + {r_acc[VALUE_W-2:0], 1'b0}
                     + {{(VALUE_W-4){1'b0}}, w_dnum[3:0]};
    assign w_hex_acc = {r_acc[VALUE_W-5:0], w_hex_d[3:0]};
    assign w_ok      = r_seen & ~r_err & (r_acc <= i_cfg.value_limit);

    always_comb begin
        n_acc   = r_acc;
        n_count = r_count;
        n_seen  = r_seen;
        n_err   = r_err;
        if (i_fire) begin
            if (w_is_nul) begin
                n_acc   = '0;
                n_count = '0;
                n_seen  = 1'b0;
                n_err   = 1'b0;
            end else begin
                n_seen = 1'b1;
                if (!r_err) begin
                    unique case (i_cfg.radix_mode)
                        RADIX_HEX: begin
                            if (w_hex_bad || w_hex_ovf) begin
                                n_err = 1'b1;
                            end else begin
                                n_acc   = w_hex_acc;
                                n_count = r_count + 5'd1;
                            end
                        end
                        default: begin
                            if (w_dec_bad || w_dec_ovf) begin
                                n_err = 1'b1;
                            end else begin
                                n_acc = w_dec_acc;
                            end
                        end
                    endcase
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc       <= '0;
            r_count     <= '0;
            r_seen      <= 1'b0;
            r_err       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_acc   <= n_acc;
            r_count <= n_count;
            r_seen  <= n_seen;
            r_err   <= n_err;
            if (i_fire && w_is_nul) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_fire && w_is_nul) begin
            r_value <= w_ok ? r_acc : '0;
            r_fail  <= ~w_ok;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_parsed_value = r_value;
    assign o_fail_flag    = r_fail;

`ifndef NO_ASSERTIONS
    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= HEX_MAX_DIGITS)
        else $error("hex digit count past limit");

    a_err_seen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_err |-> r_seen)
        else $error("error latched without a character");

    a_nul_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && w_is_nul) |=> (r_acc == '0 && r_count == '0 && !r_seen && !r_err))
        else $error("state not cleared after terminator");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_fail) |-> (r_value == '0))
        else $error("failed result carries a value");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |-> !(i_fire && w_is_nul))
        else $error("pending result overwritten");
`endif

endmodule

// File: hdl/ascii_integer_parser.sv
// ----------------------------------------------------------------------------
// ascii_integer_parser
// nul-terminated decimal or hex string to unsigned 64-bit value
// ----------------------------------------------------------------------------
// One character beat is taken per cycle. Each beat is held in an input
// register, then folded into the accumulator; a terminator loads the
// result register instead. The input only stalls when a terminator waits
// while the previous result is still held by a stalled output. Failures
// (empty string, bad digit, overflow, above value_limit) give fail_flag 1
// and value zero. Config (APB): radix_mode at 0x0, value_limit at 0x8;
// they must be written only when idle, which the block does not enforce.
module ascii_integer_parser (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [aip_pkg::PADDR_W-1:0]  paddr,
    input  logic [aip_pkg::PDATA_W-1:0]  pwdata,
    output logic [aip_pkg::PDATA_W-1:0]  prdata,
    output logic                         pready,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic [aip_pkg::CHAR_W-1:0]   i_char_code,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic [aip_pkg::VALUE_W-1:0]  o_parsed_value,
    output logic                         o_fail_flag
);
    import aip_pkg::*;

    t_cfg              w_cfg;
    logic              r_in_valid, n_in_valid;
    logic [CHAR_W-1:0] r_char;
    logic              w_fire;
    logic              w_accept;

    aip_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // a held terminator waits for the result register to free up
    assign w_fire     = r_in_valid
                      & ~((r_char == CHAR_NUL) & o_out_valid & i_out_stall);
    assign o_in_stall = r_in_valid & ~w_fire;
    assign w_accept   = i_in_valid & ~o_in_stall;
    assign n_in_valid = w_accept | (r_in_valid & ~w_fire);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= n_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_char <= i_char_code;
        end
    end

    aip_accum u_accum (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_fire         (w_fire),
        .i_char         (r_char),
        .i_cfg          (w_cfg),
        .i_out_stall    (i_out_stall),
        .o_out_valid    (o_out_valid),
        .o_parsed_value (o_parsed_value),
        .o_fail_flag    (o_fail_flag)
    );

`ifndef NO_ASSERTIONS
    a_fire_needs_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fire |-> r_in_valid)
        else $error("fire without a held beat");

    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !w_fire) |=> (r_in_valid && $stable(r_char)))
        else $error("held beat lost");

    a_stall_only_nul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_char == CHAR_NUL && o_out_valid))
        else $error("stall without a pending terminator");
`endif

endmodule

// File: tb/aip_result_checker.sv
// ----------------------------------------------------------------------------
// aip_result_checker
// predicts every result beat of the ascii integer parser and compares it
// ----------------------------------------------------------------------------
module aip_result_checker (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_psel,
    input  logic                         i_penable,
    input  logic                         i_pwrite,
    input  logic                         i_pready,
    input  logic [aip_pkg::PADDR_W-1:0]  i_paddr,
    input  logic [aip_pkg::PDATA_W-1:0]  i_pwdata,
    input  logic                         i_in_valid,
    input  logic                         i_in_stall,
    input  logic [aip_pkg::CHAR_W-1:0]   i_char_code,
    input  logic                         i_out_valid,
    input  logic                         i_out_stall,
    input  logic [aip_pkg::VALUE_W-1:0]  i_parsed_value,
    input  logic                         i_fail_flag,
    input  logic                         i_flush,
    output int                           o_pending,
    output int                           o_errors
);
    timeunit 1ns;
    timeprecision 1ps;

    import aip_pkg::*;

    typedef struct packed {
        logic [VALUE_W-1:0] acc;
        logic [COUNT_W-1:0] hex_digits;
        logic               seen;
        logic               failed;
    } t_parse_state;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic               fail;
    } t_parse_result;

    t_parse_state  string_state = '0;
    t_cfg          shadow_cfg;
    t_parse_result owed_results[$];
    int            mismatch_count = 0;
    int            owed_count = 0;

    assign o_pending = owed_count;
    assign o_errors  = mismatch_count;

    initial begin
        shadow_cfg.radix_mode  = RADIX_DEC;
        shadow_cfg.value_limit = LIMIT_RESET;
    end

    function automatic t_parse_state fold_char(input t_parse_state st,
                                               input logic [CHAR_W-1:0] c,
                                               input logic radix);
        logic [CHAR_W-1:0] d;
        logic              bad;
        t_parse_state      nx;
        nx      = st;
        nx.seen = 1'b1;
        bad     = 1'b0;
        d       = c - CHAR_ZERO;
        if (!st.failed) begin
            if (radix == RADIX_HEX) begin
                if (d > DEC_MAX) begin
                    d = (c | CASE_BIT) - CHAR_LOWER_A;
                    if (d > HEX_ALPHA_MAX) begin
                        bad = 1'b1;
                    end else begin
                        d = d + HEX_TEN;
                    end
                end
                if (bad || st.hex_digits >= HEX_MAX_DIGITS) begin
                    nx.failed = 1'b1;
                end else begin
                    nx.hex_digits = st.hex_digits + 1'b1;
                    nx.acc        = {st.acc[VALUE_W-5:0], d[3:0]};
                end
            end else begin
                if (d > DEC_MAX) begin
                    nx.failed = 1'b1;
                end else if (st.acc > DEC_QUOT_LIMIT ||
                             (st.acc == DEC_QUOT_LIMIT && d > DEC_TOP_DIGIT)) begin
                    nx.failed = 1'b1;
                end else begin
                    nx.acc = st.acc * 64'd10 + VALUE_W'(d);
                end
            end
        end
        return nx;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        mismatch_count++;
    endtask

    always @(posedge i_clk) begin : watch_beats
        t_parse_result want;
        logic          ok;
        if (!i_rst_n) begin
            string_state           = '0;
            shadow_cfg.radix_mode  = RADIX_DEC;
            shadow_cfg.value_limit = LIMIT_RESET;
            owed_results.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (owed_results.size() == 0) begin
                    report_mismatch($sformatf("result beat %h/%b with no string ended",
                                              i_parsed_value, i_fail_flag));
                end else begin
                    want = owed_results.pop_front();
                    if (i_parsed_value !== want.value) begin
                        report_mismatch($sformatf("parsed_value %h, predicted %h",
                                                  i_parsed_value, want.value));
                    end
                    if (i_fail_flag !== want.fail) begin
                        report_mismatch($sformatf("fail_flag %b, predicted %b",
                                                  i_fail_flag, want.fail));
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                if (i_char_code != CHAR_NUL) begin
                    string_state = fold_char(string_state, i_char_code,
                                             shadow_cfg.radix_mode);
                end else begin
                    ok = string_state.seen && !string_state.failed &&
                         string_state.acc <= shadow_cfg.value_limit;
                    want.value = ok ? string_state.acc : '0;
                    want.fail  = !ok;
                    owed_results.push_back(want);
                    string_state = '0;
                end
            end
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                if (i_paddr[3] == REG_VALUE_LIMIT) begin
                    shadow_cfg.value_limit = i_pwdata[VALUE_W-1:0];
                end else begin
                    shadow_cfg.radix_mode = i_pwdata[0];
                end
            end
            if (i_flush) begin
                while (owed_results.size() != 0) begin
                    want = owed_results.pop_front();
                    report_mismatch($sformatf("result %h/%b never arrived",
                                              want.value, want.fail));
                end
            end
        end
        owed_count = owed_results.size();
    end

endmodule

// File: tb/tb_ascii_integer_parser.sv
// ----------------------------------------------------------------------------
// tb_ascii_integer_parser
// directed and random strings with bursty input and patterned output stalls
// ----------------------------------------------------------------------------
module tb_ascii_integer_parser;
    timeunit 1ns;
    timeprecision 1ps;

    import aip_pkg::*;

    localparam int IDLE_LIMIT    = 4000;
    localparam int SETTLE_CYCLES = 4;
    localparam int DRAIN_CYCLES  = 8;
    localparam int LONG_HOLD     = 400;
    localparam int HOLD_START    = 1500;
    localparam int PHASE_ITEMS   = 240;

    logic               i_clk       = 1'b0;
    logic               i_rst_n     = 1'b0;
    logic               psel        = 1'b0;
    logic               penable     = 1'b0;
    logic               pwrite      = 1'b0;
    logic [PADDR_W-1:0] paddr       = '0;
    logic [PDATA_W-1:0] pwdata      = '0;
    logic [PDATA_W-1:0] prdata;
    logic               pready;
    logic               i_in_valid  = 1'b0;
    logic               o_in_stall;
    logic [CHAR_W-1:0]  i_char_code = '0;
    logic               o_out_valid;
    logic               i_out_stall = 1'b0;
    logic [VALUE_W-1:0] o_parsed_value;
    logic               o_fail_flag;

    logic               flush = 1'b0;
    int                 pending;
    int                 errors;

    logic [CHAR_W-1:0]  char_buf[$];
    logic               cur_radix = RADIX_DEC;
    int                 gap_pct = 0;
    int                 burst_left = 0;
    int                 chars_sent = 0;

    always #5 i_clk = ~i_clk;

    ascii_integer_parser u_top (.*);

    aip_result_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_psel         (psel),
        .i_penable      (penable),
        .i_pwrite       (pwrite),
        .i_pready       (pready),
        .i_paddr        (paddr),
        .i_pwdata       (pwdata),
        .i_in_valid     (i_in_valid),
        .i_in_stall     (o_in_stall),
        .i_char_code    (i_char_code),
        .i_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .i_parsed_value (o_parsed_value),
        .i_fail_flag    (o_fail_flag),
        .i_flush        (flush),
        .o_pending      (pending),
        .o_errors       (errors)
    );

    function automatic logic [VALUE_W-1:0] rand_value();
        logic [VALUE_W-1:0] v;
        v = {$urandom, $urandom};
        return v >> $urandom_range(0, VALUE_W - 1);
    endfunction

    task automatic send_char(input logic [CHAR_W-1:0] c);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 99) < gap_pct) ? $urandom_range(1, 8) : 0;
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        burst_left--;
        i_in_valid  <= 1'b1;
        i_char_code <= c;
        do @(posedge i_clk); while (o_in_stall);
        @(negedge i_clk);
        chars_sent++;
    endtask

    task automatic send_buffer(input bit terminate);
        foreach (char_buf[k]) send_char(char_buf[k]);
        if (terminate) send_char(CHAR_NUL);
        char_buf.delete();
    endtask

    task automatic send_text(input string s, input bit terminate);
        for (int k = 0; k < s.len(); k++) char_buf.push_back(s[k]);
        send_buffer(terminate);
    endtask

    task automatic push_number(input logic [VALUE_W-1:0] v, input int zeros);
        string             s;
        logic [CHAR_W-1:0] c;
        repeat (zeros) char_buf.push_back(CHAR_ZERO);
        if (cur_radix == RADIX_HEX) s = $sformatf("%0h", v);
        else s = $sformatf("%0d", v);
        for (int k = 0; k < s.len(); k++) begin
            c = s[k];
            if (c >= CHAR_LOWER_A && $urandom_range(0, 1) == 1) c = c & ~CASE_BIT;
            char_buf.push_back(c);
        end
    endtask

    task automatic push_digit();
        if (cur_radix == RADIX_HEX) push_number(VALUE_W'($urandom_range(0, 15)), 0);
        else char_buf.push_back(CHAR_ZERO + CHAR_W'($urandom_range(0, 9)));
    endtask

    task automatic send_random_string(input bit terminate);
        int                 kind;
        int                 variant;
        int                 width;
        string              hex_text;
        logic [VALUE_W-1:0] v;
        kind     = $urandom_range(0, 99);
        variant  = $urandom_range(0, 3);
        v        = rand_value();
        hex_text = $sformatf("%0h", v);
        width    = hex_text.len();
        if (kind < 5) begin
            // empty string
        end else if (kind < 65) begin
            push_number(v, ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0);
        end else if (kind < 77) begin
            if (cur_radix == RADIX_HEX) begin
                if (variant == 0) push_number(v, 16 - width);
                else if (variant == 1) push_number(v, 17 - width);
                else if (variant == 2) push_number(LIMIT_RESET, $urandom_range(0, 1));
                else begin
                    push_number(v, 16 - width);
                    push_digit();
                end
            end else begin
                if (variant == 0) push_number(LIMIT_RESET, $urandom_range(0, 1));
                else if (variant == 1) begin
                    push_number(DEC_QUOT_LIMIT, 0);
                    push_digit();
                end else if (variant == 2) begin
                    push_number(DEC_QUOT_LIMIT + 1'b1, 0);
                    push_digit();
                end else begin
                    push_number(v, 0);
                    push_digit();
                end
            end
        end else if (kind < 92) begin
            push_number(v, 0);
            char_buf.insert($urandom_range(0, char_buf.size() - 1),
                            CHAR_W'($urandom_range(1, 255)));
        end else begin
            repeat ($urandom_range(1, 6)) char_buf.push_back(CHAR_W'($urandom_range(1, 255)));
        end
        send_buffer(terminate);
    endtask

    task automatic settle();
        i_in_valid <= 1'b0;
        burst_left = 0;
        while (pending != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic apb_write(input logic idx, input logic [PDATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'({idx, 3'b000});
        pwdata  <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic run_phase(input logic radix, input logic [VALUE_W-1:0] limit,
                             input int gaps);
        int start;
        settle();
        apb_write(REG_RADIX_MODE, PDATA_W'(radix));
        apb_write(REG_VALUE_LIMIT, limit);
        cur_radix = radix;
        gap_pct   = gaps;
        start     = chars_sent;
        while (chars_sent - start < PHASE_ITEMS) send_random_string(1'b1);
        // sometimes leave a string open across the register change
        if ($urandom_range(0, 1) == 1) send_random_string(1'b0);
    endtask

    initial begin : stimulus
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        gap_pct = 30;

        send_char(CHAR_NUL);
        send_text("09", 1'b1);
        send_char(8'hFF);
        send_char(CHAR_NUL);
        send_text("/1", 1'b1);
        send_text(":", 1'b1);

        settle();
        apb_write(REG_VALUE_LIMIT, 64'd5);
        send_text("7", 1'b1);
        send_text("5", 1'b1);

        settle();
        apb_write(REG_VALUE_LIMIT, LIMIT_RESET);
        apb_write(REG_RADIX_MODE, PDATA_W'(RADIX_HEX));
        cur_radix = RADIX_HEX;
        send_text("aF9", 1'b1);
        send_text("g", 1'b1);
        send_text("@", 1'b1);
        send_text("G", 1'b1);
        // radix switches in the middle of a string
        send_text("1", 1'b0);
        settle();
        apb_write(REG_RADIX_MODE, PDATA_W'(RADIX_DEC));
        cur_radix = RADIX_DEC;
        send_text("2", 1'b1);

        run_phase(RADIX_DEC, LIMIT_RESET, 0);
        run_phase(RADIX_HEX, LIMIT_RESET, 30);
        run_phase(RADIX_DEC, '0, 40);
        run_phase(RADIX_HEX, rand_value(), 20);
        run_phase(RADIX_DEC, rand_value(), 50);
        run_phase(RADIX_HEX, '0, 10);
        run_phase(RADIX_HEX, rand_value(), 30);
        run_phase(RADIX_DEC, LIMIT_RESET, 25);

        settle();
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        flush <= 1'b1;
        @(negedge i_clk);
        flush <= 1'b0;
        @(negedge i_clk);
        if (errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    initial begin : receiver
        int  cycles = 0;
        bit  held = 1'b0;
        int  pct;
        forever begin
            if ((!held && cycles >= HOLD_START) || $urandom_range(0, 199) == 0) begin
                held = 1'b1;
                repeat (LONG_HOLD) begin
                    @(negedge i_clk);
                    i_out_stall <= 1'b1;
                    cycles++;
                end
            end else begin
                pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(10, 80);
                repeat ($urandom_range(20, 120)) begin
                    @(negedge i_clk);
                    i_out_stall <= ($urandom_range(0, 99) < pct);
                    cycles++;
                end
            end
        end
    end

    initial begin : watchdog
        int idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
                (psel && penable && pwrite && pready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("Verification failed");
        $finish;
    end

endmodule

// File: files.f
hdl/aip_pkg.sv
hdl/aip_cfg_regs.sv
hdl/aip_accum.sv
hdl/ascii_integer_parser.sv
tb/aip_result_checker.sv
tb/tb_ascii_integer_parser.sv
